// File: design/at_response_ipd_parser_assert.svh
// assertion macros for the ipd response parser
`ifndef AT_RESPONSE_IPD_PARSER_ASSERT_SVH
`define AT_RESPONSE_IPD_PARSER_ASSERT_SVH

// same-cycle implication, checked on clk outside reset
`define ATIPD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk outside reset
`define ATIPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/atipd_pkg.sv
// shared types and constants for the ipd response parser
package atipd_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 16;

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_PLUS   = 4'd1,
		PH_I      = 4'd2,
		PH_P      = 4'd3,
		PH_D      = 4'd4,
		PH_ID     = 4'd5,
		PH_COMMA2 = 4'd6,
		PH_LEN    = 4'd7,
		PH_DATA   = 4'd8,
		PH_DIGIT  = 4'd9,
		PH_DIGCOM = 4'd10,
		PH_SKIP   = 4'd11
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_PROMPT = 3'd1,
		EV_BUSY   = 3'd2,
		EV_ERROR  = 3'd3,
		EV_CONN   = 3'd4
	} event_t;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_L      = 8'h6C;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam int unsigned RADIX = 10;

	typedef struct packed {
		logic         payload_valid;
		logic [7:0]   payload_byte;
		logic [3:0]   payload_client;
		logic         payload_last;
		event_t       event_code;
		logic         parser_idle;
	} res_t;

endpackage

// File: design/atipd_rx_if.sv
// input channel: one received byte per word
interface atipd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/atipd_res_if.sv
// result channel: one parse result per word
interface atipd_res_if;
	logic       valid;
	logic       ready;
	logic       payload_valid;
	logic [7:0] payload_byte;
	logic [3:0] payload_client;
	logic       payload_last;
	logic [2:0] event_code;
	logic       parser_idle;

	modport source (output valid, output payload_valid, output payload_byte,
		output payload_client, output payload_last, output event_code,
		output parser_idle, input ready);
	modport sink (input valid, input payload_valid, input payload_byte,
		input payload_client, input payload_last, input event_code,
		input parser_idle, output ready);
endinterface

// File: design/at_response_ipd_parser.sv
// top level of the modem ipd response parser
// usage:
//  rx  : one modem response byte per word (valid/ready)
//  res : one result word per accepted byte, carrying payload byte, client id,
//        last mark, event code and a line-start flag
//  the result word is registered: a byte accepted at one edge gives its result word
//  at the output from the next cycle on
//  throughput is one byte per cycle while the receiver keeps taking results; the parse state and the result register
//  update together, so a new byte is taken while the previous result is
//  being taken by the receiver
//  when the receiver stalls with a result pending, rx ready drops and the
//  held word stays on res until it is taken
//  "+IPD,id,len:" opens a frame of len payload bytes; len is accumulated
//  modulo 2^LENGTH_BITS, a zero length goes straight back to line start
//  reset puts the parser at line start, clears length and client, and
//  empties the result register
`include "at_response_ipd_parser_assert.svh"

module at_response_ipd_parser #(
	parameter int unsigned LENGTH_BITS = atipd_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	atipd_rx_if.sink          rx,
	atipd_res_if.source       res
);

	// parse state
	atipd_pkg::phase_t         phase_q, phase_d;
	logic [LENGTH_BITS-1:0]    len_q, len_d;
	logic [3:0]                client_q, client_d;

	// result register
	logic                      res_valid_q;
	atipd_pkg::res_t           res_q, res_d;

	logic                      in_accept;
	logic [7:0]                c;
	logic                      c_digit;
	logic [LENGTH_BITS-1:0]    len_dec;
	logic [LENGTH_BITS-1:0]    len_acc;

	// accept whenever the result slot is empty or is being drained
	assign rx.ready  = !res_valid_q || res.ready;
	assign in_accept = rx.valid && rx.ready;

	assign c       = rx.rx_byte;
	assign c_digit = (c >= atipd_pkg::CH_ZERO) && (c <= atipd_pkg::CH_NINE);

	// len*10 + c - '0', as shifts and adds, wrapped to the length width
	assign len_acc = (len_q << 3) + (len_q << 1)
		+ LENGTH_BITS'(c) - LENGTH_BITS'(atipd_pkg::CH_ZERO);
	assign len_dec = len_q - LENGTH_BITS'(1);

	always_comb begin
		phase_d  = phase_q;
		len_d    = len_q;
		client_d = client_q;
		res_d    = '0;
		res_d.event_code = atipd_pkg::EV_NONE;

		case (phase_q)
			atipd_pkg::PH_START: begin
				if (c == atipd_pkg::CH_PLUS) begin
					phase_d = atipd_pkg::PH_PLUS;
				end else if (c == atipd_pkg::CH_GT) begin
					res_d.event_code = atipd_pkg::EV_PROMPT;
					phase_d = atipd_pkg::PH_SKIP;
				end else if (c == atipd_pkg::CH_R || c == atipd_pkg::CH_S) begin
					phase_d = atipd_pkg::PH_SKIP;
				end else if (c == atipd_pkg::CH_B) begin
					res_d.event_code = atipd_pkg::EV_BUSY;
					phase_d = atipd_pkg::PH_SKIP;
				end else if (c_digit) begin
					// ascii digit: low nibble is its value
					client_d = c[3:0];
					phase_d  = atipd_pkg::PH_DIGIT;
				end else if (c == atipd_pkg::CH_E || c == atipd_pkg::CH_L) begin
					res_d.event_code = atipd_pkg::EV_ERROR;
					phase_d = atipd_pkg::PH_SKIP;
				end
			end
			atipd_pkg::PH_PLUS: begin
				phase_d = (c == atipd_pkg::CH_I) ? atipd_pkg::PH_I : atipd_pkg::PH_SKIP;
			end
			atipd_pkg::PH_I: begin
				phase_d = (c == atipd_pkg::CH_P) ? atipd_pkg::PH_P : atipd_pkg::PH_SKIP;
			end
			atipd_pkg::PH_P: begin
				phase_d = (c == atipd_pkg::CH_D) ? atipd_pkg::PH_D : atipd_pkg::PH_SKIP;
			end
			atipd_pkg::PH_D: begin
				phase_d = (c == atipd_pkg::CH_COMMA) ? atipd_pkg::PH_ID : atipd_pkg::PH_SKIP;
			end
			atipd_pkg::PH_ID: begin
				if (c_digit) begin
					client_d = c[3:0];
					phase_d  = atipd_pkg::PH_COMMA2;
				end else begin
					phase_d = atipd_pkg::PH_SKIP;
				end
			end
			atipd_pkg::PH_COMMA2: begin
				phase_d = (c == atipd_pkg::CH_COMMA) ? atipd_pkg::PH_LEN : atipd_pkg::PH_SKIP;
				len_d   = '0;
			end
			atipd_pkg::PH_LEN: begin
				if (c == atipd_pkg::CH_COLON) begin
					// a length that wrapped to zero counts as empty
					phase_d = (len_q == '0) ? atipd_pkg::PH_START : atipd_pkg::PH_DATA;
				end else begin
					len_d = len_acc;
				end
			end
			atipd_pkg::PH_DATA: begin
				res_d.payload_valid  = 1'b1;
				res_d.payload_byte   = c;
				res_d.payload_client = client_q;
				len_d = len_dec;
				if (len_dec == '0) begin
					res_d.payload_last = 1'b1;
					phase_d = atipd_pkg::PH_START;
				end
			end
			atipd_pkg::PH_DIGIT: begin
				phase_d = (c == atipd_pkg::CH_COMMA) ? atipd_pkg::PH_DIGCOM
					: atipd_pkg::PH_SKIP;
			end
			atipd_pkg::PH_DIGCOM: begin
				if (c == atipd_pkg::CH_C) begin
					res_d.event_code = atipd_pkg::EV_CONN;
				end
				phase_d = atipd_pkg::PH_SKIP;
			end
			atipd_pkg::PH_SKIP: begin
				if (c == atipd_pkg::CH_NL) begin
					phase_d = atipd_pkg::PH_START;
				end
			end
			default: begin
				phase_d = atipd_pkg::PH_START;
			end
		endcase

		res_d.parser_idle = (phase_d == atipd_pkg::PH_START);
	end

	// parse state advances only on an accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= atipd_pkg::PH_START;
			len_q    <= '0;
			client_q <= '0;
		end else if (in_accept) begin
			phase_q  <= phase_d;
			len_q    <= len_d;
			client_q <= client_d;
		end
	end

	// result slot: filled on accept, emptied when taken without refill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_accept) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			res_q <= res_d;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.payload_valid  = res_q.payload_valid;
	assign res.payload_byte   = res_q.payload_byte;
	assign res.payload_client = res_q.payload_client;
	assign res.payload_last   = res_q.payload_last;
	assign res.event_code     = res_q.event_code;
	assign res.parser_idle    = res_q.parser_idle;

	// the payload phase never holds an exhausted length
	`ATIPD_ASSERT_NOW(a_data_len_nonzero, phase_q == atipd_pkg::PH_DATA, len_q != '0,
		"payload phase with zero remaining length")

	// non-payload words carry zero payload fields
	`ATIPD_ASSERT_NOW(a_payload_zero, res_valid_q && !res_q.payload_valid,
		res_q.payload_byte == '0 && res_q.payload_client == '0 && !res_q.payload_last,
		"payload fields set on a non-payload word")

	// the idle flag of a fresh result matches the state it left behind
	`ATIPD_ASSERT_NEXT(a_idle_matches, in_accept,
		res_q.parser_idle == (phase_q == atipd_pkg::PH_START),
		"idle flag disagrees with parse state")

	// the final byte of a frame returns the parser to line start
	`ATIPD_ASSERT_NEXT(a_last_to_start,
		in_accept && phase_q == atipd_pkg::PH_DATA && len_q == LENGTH_BITS'(1),
		phase_q == atipd_pkg::PH_START && res_q.payload_last,
		"final payload byte did not close the frame")

endmodule
